// ===== hdl/tnww_pkg.sv =====
// shared constants, character class decode and replacement text for the text reflow block
package tnww_pkg;

    localparam int MAX_WORD_DEF = 10;
    localparam int LONG_LEN     = 6;

    localparam logic [7:0] CHAR_NL        = 8'd10;
    localparam logic [7:0] CHAR_SP        = 8'd32;
    localparam logic [7:0] DEF_LINE_WIDTH = 8'd40;

    localparam logic [0:0] ADDR_LINE_WIDTH = 1'b0;

    typedef logic [1:0] char_cls_t;

    localparam char_cls_t CLS_DROP  = 2'd0;
    localparam char_cls_t CLS_ALNUM = 2'd1;
    localparam char_cls_t CLS_PUNCT = 2'd2;
    localparam char_cls_t CLS_SPACE = 2'd3;

    function automatic char_cls_t char_class(input logic [7:0] c);
        char_cls_t cls;
        cls = CLS_DROP;
        if (c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]})
        begin
            cls = CLS_ALNUM;
        end
        else if (c inside {[8'd33:8'd47], [8'd58:8'd64], [8'd91:8'd96], [8'd123:8'd126]})
        begin
            cls = CLS_PUNCT;
        end
        else if (c inside {[8'd9:8'd13], 8'd32})
        begin
            cls = CLS_SPACE;
        end
        return cls;
    endfunction

    // text that stands in for an over-long word
    function automatic logic [7:0] long_word_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h56;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h75;
            default: ch = 8'h21;
        endcase
        return ch;
    endfunction

endpackage

// ===== hdl/tnww_word_ram.sv =====
// single-port-write, registered-read buffer holding the bytes of the current word
module tnww_word_ram #(
    parameter int DEPTH  = tnww_pkg::MAX_WORD_DEF,
    parameter int ADDR_W = $clog2(tnww_pkg::MAX_WORD_DEF)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/text_normalize_and_word_wrap.sv =====
// text reflow: whitespace collapse, punctuation join, long-word replacement, greedy wrap
//
// input stream s_*: s_tdata carries one text byte, s_tuser marks end of text
// (the byte is ignored then). output stream m_*: m_tdata is one output byte,
// m_tlast marks the last byte caused by one input request.
// APB port: register line_width at address 0; the user must write it only
// while idle, the block does not enforce this. a byte that does not end a
// word is taken while idle and gives no output. a byte that ends a word
// commits it: an optional line break, then each word byte is read from the
// word buffer and loaded into the output register (a read state and a load
// state per byte), then the trailing space, then on end of text the final
// break. a committed word is at most MAX_WORD bytes long.
// s_tready is low while a word is being emitted; a request that commits
// nothing is taken even while the output register still holds a byte.
// a stall on m_tready holds the output register and the emit sequence.
// reset empties the word, clears the line and sets line_width to 40; the
// word buffer needs no clearing since only bytes of the current word are read.
module text_normalize_and_word_wrap #(
    parameter int MAX_WORD = tnww_pkg::MAX_WORD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_char
    input  logic       s_tuser,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_char
    output logic       m_tlast,   // last_of_run
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [0:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    import tnww_pkg::*;

    localparam int CNT_W = $clog2(MAX_WORD + 2);
    localparam int IDX_W = $clog2(MAX_WORD);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BREAK = 3'd1;
    localparam logic [2:0] ST_RD    = 3'd2;
    localparam logic [2:0] ST_WR    = 3'd3;
    localparam logic [2:0] ST_SPACE = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] wc_reg, wc_next;
    logic             sp_pend_reg, sp_pend_next;
    logic [8:0]       fill_reg, fill_next;
    logic [7:0]       lw_reg;
    logic [CNT_W-1:0] len_reg, len_next;
    logic             long_reg, long_next;
    logic             final_reg, final_next;
    logic             pend_reg, pend_next;
    logic [7:0]       pend_char_reg, pend_char_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             out_free;
    logic             ld_out;
    char_cls_t        cls;
    logic             wc_long;
    logic [CNT_W-1:0] cur_len;
    logic             need_brk;
    logic             cfg_we;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    tnww_word_ram #(
        .DEPTH  (MAX_WORD),
        .ADDR_W (IDX_W)
    ) u_word_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign pready = 1'b1;
    assign prdata = {24'd0, lw_reg};
    assign cfg_we = psel && penable && pwrite && pready && (paddr == ADDR_LINE_WIDTH);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign cls      = char_class(s_tdata);
    assign wc_long  = (wc_reg > CNT_W'(MAX_WORD));
    assign cur_len  = wc_long ? CNT_W'(LONG_LEN) : wc_reg;
    assign need_brk = (fill_reg != 9'd0) &&
                      (({1'b0, fill_reg} + 10'(cur_len)) > {2'b00, lw_reg});

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        wc_next        = wc_reg;
        sp_pend_next   = sp_pend_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        long_next      = long_reg;
        final_next     = final_reg;
        pend_next      = pend_reg;
        pend_char_next = pend_char_reg;
        rd_idx_next    = rd_idx_reg;
        ld_out         = 1'b0;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = wc_reg[IDX_W-1:0];
        ram_wdata      = s_tdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        sp_pend_next = 1'b0;
                        final_next   = 1'b1;
                        pend_next    = 1'b0;
                        if (wc_reg != '0)
                        begin
                            len_next    = cur_len;
                            long_next   = wc_long;
                            rd_idx_next = '0;
                            state_next  = need_brk ? ST_BREAK : ST_RD;
                        end
                        else
                        begin
                            state_next = ST_FINAL;
                        end
                    end
                    else
                    begin
                        case (cls)
                            CLS_ALNUM, CLS_PUNCT:
                            begin
                                sp_pend_next = 1'b0;
                                if (cls == CLS_ALNUM && sp_pend_reg && wc_reg != '0)
                                begin
                                    // commit held word, append this byte afterward
                                    final_next     = 1'b0;
                                    pend_next      = 1'b1;
                                    pend_char_next = s_tdata;
                                    len_next       = cur_len;
                                    long_next      = wc_long;
                                    rd_idx_next    = '0;
                                    state_next     = need_brk ? ST_BREAK : ST_RD;
                                end
                                else
                                begin
                                    ram_we = (wc_reg < CNT_W'(MAX_WORD));
                                    if (wc_reg <= CNT_W'(MAX_WORD))
                                    begin
                                        wc_next = wc_reg + 1'b1;
                                    end
                                end
                            end
                            CLS_SPACE:
                            begin
                                sp_pend_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_BREAK:
            begin
                if (out_free)
                begin
                    ld_out        = 1'b1;
                    out_char_next = CHAR_NL;
                    out_last_next = 1'b0;
                    fill_next     = 9'd0;
                    state_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (out_free)
                begin
                    ld_out        = 1'b1;
                    out_char_next = long_reg ? long_word_char(rd_idx_reg[2:0]) : ram_rdata;
                    out_last_next = 1'b0;
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    state_next    = (rd_idx_next == len_reg) ? ST_SPACE : ST_RD;
                end
            end
            ST_SPACE:
            begin
                if (out_free)
                begin
                    ld_out        = 1'b1;
                    out_char_next = CHAR_SP;
                    out_last_next = !final_reg;
                    fill_next     = fill_reg + 9'(len_reg) + 9'd1;
                    if (pend_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = pend_char_reg;
                        wc_next   = CNT_W'(1);
                    end
                    else
                    begin
                        wc_next = '0;
                    end
                    pend_next  = 1'b0;
                    state_next = final_reg ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    ld_out        = 1'b1;
                    out_char_next = CHAR_NL;
                    out_last_next = 1'b1;
                    fill_next     = 9'd0;
                    wc_next       = '0;
                    final_next    = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wc_reg        <= '0;
            sp_pend_reg   <= 1'b0;
            fill_reg      <= 9'd0;
            lw_reg        <= DEF_LINE_WIDTH;
            final_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            sp_pend_reg   <= sp_pend_next;
            fill_reg      <= fill_next;
            final_reg     <= final_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                lw_reg <= pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        long_reg      <= long_next;
        pend_char_reg <= pend_char_next;
        rd_idx_reg    <= rd_idx_next;
        out_char_reg  <= out_char_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // word length saturates one past the buffer depth
    a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= CNT_W'(MAX_WORD + 1))
        else $error("word count beyond saturation");

    // a break before a word only ever ends a nonempty line
    a_break_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BREAK) |-> (fill_reg != 9'd0))
        else $error("line break on empty line");

    // buffer reads stay inside the committed word
    a_rd_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_WR) |-> (rd_idx_reg < len_reg))
        else $error("word read past its length");

    // the byte that closes a request hands control back to the input side
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ld_out && out_last_next) |=> (state_reg == ST_IDLE))
        else $error("last byte emitted but sequence goes on");
`endif

endmodule

// ===== verif/text_normalize_and_word_wrap_test.sv =====
// self-checking testbench for the text reflow and greedy word wrap block
`timescale 1ns / 100ps

module text_normalize_and_word_wrap_test;
    import tnww_pkg::*;

    localparam int WORD_MAX  = MAX_WORD_DEF;
    localparam int SETTLE    = 30;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } out_byte_t;

    class wrap_model;
        logic [7:0] width;
        logic [7:0] word_buf [WORD_MAX];
        logic [7:0] long_text [6];
        int         word_len;
        bit         gap_seen;
        logic [8:0] fill;
        out_byte_t  expected_chars [$];
        int         mismatches;
        int         checked;
        int         texts;
        int         long_words;

        function new();
            width      = DEF_LINE_WIDTH;
            word_len   = 0;
            gap_seen   = 1'b0;
            fill       = '0;
            mismatches = 0;
            checked    = 0;
            texts      = 0;
            long_words = 0;
            long_text  = '{"V", "a", "u", "!", "!", "!"};
        endfunction

        function void set_width(logic [7:0] w);
            width = w;
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction

        function char_cls_t classify(logic [7:0] c);
            if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
                return CLS_ALNUM;
            if ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126))
                return CLS_PUNCT;
            if ((c >= 8'd9 && c <= 8'd13) || c == CHAR_SP)
                return CLS_SPACE;
            return CLS_DROP;
        endfunction

        function void push(logic [7:0] c);
            out_byte_t item;
            item.ch   = c;
            item.last = 1'b0;
            expected_chars = {expected_chars, item};
        endfunction

        function void append(logic [7:0] c);
            if (word_len < WORD_MAX)
                word_buf[word_len] = c;
            if (word_len <= WORD_MAX)
                word_len++;
        endfunction

        function void flush_word();
            int  n;
            int  i;
            bit  over;
            if (word_len == 0)
                return;
            over = word_len > WORD_MAX;
            n = over ? 6 : word_len;
            if (over)
                long_words++;
            if (fill != 0 && int'(fill) + n > int'(width))
            begin
                push(CHAR_NL);
                fill = '0;
            end
            for (i = 0; i < n; i++)
                push(over ? long_text[i] : word_buf[i]);
            push(CHAR_SP);
            fill = 9'(int'(fill) + n + 1);
            word_len = 0;
        endfunction

        // predict the output bytes caused by one accepted request
        function void take_byte(logic [7:0] c, logic eot);
            int        prior;
            prior = expected_chars.size();
            if (eot)
            begin
                flush_word();
                push(CHAR_NL);
                word_len = 0;
                gap_seen = 1'b0;
                fill     = '0;
                texts++;
            end
            else
            begin
                case (classify(c))
                    CLS_ALNUM:
                    begin
                        if (gap_seen)
                            flush_word();
                        gap_seen = 1'b0;
                        append(c);
                    end
                    CLS_PUNCT:
                    begin
                        gap_seen = 1'b0;
                        append(c);
                    end
                    CLS_SPACE: gap_seen = 1'b1;
                    default: ;
                endcase
            end
            if (expected_chars.size() > prior)
                expected_chars[expected_chars.size() - 1].last = 1'b1;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $time, msg);
        endfunction

        function void check_byte(logic [7:0] ch, logic last);
            out_byte_t want;
            checked++;
            if (expected_chars.size() == 0)
            begin
                flag($sformatf("unexpected output byte %0d last %0b", ch, last));
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last)
                flag($sformatf("output byte mismatch: expected %0d last %0b, got %0d last %0b",
                               want.ch, want.last, ch, last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // in_char
    logic        s_tuser;    // end_of_text
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // out_char
    logic        m_tlast;    // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    wrap_model model;
    bit        tx_quiet;
    bit        rx_quiet;
    int        hold_reqs;
    int        holds_done;
    int        req_count;
    logic [7:0] mid_width;

    text_normalize_and_word_wrap DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random hold-off per byte, plus one long stall on request
    initial
    begin
        int rx_wait;
        rx_wait    = 0;
        holds_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                rx_wait = LONG_HOLD;
            end
            else if (m_tvalid && m_tready)
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 5);
            else if (rx_wait > 0)
                rx_wait--;
            m_tready <= (rx_wait == 0) && rst_n;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            model.check_byte(m_tdata, m_tlast);
    end

    task automatic send_item(logic [7:0] c, logic eot);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eot;
        do @(posedge clk); while (!s_tready);
        model.take_byte(c, eot);
        req_count++;
    endtask

    task automatic send_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 10)
            return 8'("0" + r);
        if (r < 36)
            return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    function automatic logic [7:0] pick_punct();
        int r;
        r = $urandom_range(0, 31);
        if (r < 15)
            return 8'(33 + r);
        if (r < 22)
            return 8'(58 + r - 15);
        if (r < 28)
            return 8'(91 + r - 22);
        return 8'(123 + r - 28);
    endfunction

    function automatic logic [7:0] pick_space();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(9, 13)) : CHAR_SP;
    endfunction

    function automatic logic [7:0] pick_drop();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(0, 8));
            1:       return 8'($urandom_range(14, 31));
            default: return 8'($urandom_range(127, 255));
        endcase
    endfunction

    task automatic random_phase(int n);
        int start;
        int len;
        int i;
        int k;
        int t;
        start = req_count;
        while (req_count - start < n)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 8);
            for (i = 0; i < len; i++)
                send_item(($urandom_range(0, 7) == 0) ? pick_punct() : pick_alnum(), 1'b0);
            t = $urandom_range(0, 9);
            if (t == 0)
                send_item(8'($urandom_range(0, 255)), 1'b1);
            else if (t == 1)
            begin
                send_item(CHAR_SP, 1'b0);
                send_item(pick_punct(), 1'b0);
                send_item(pick_space(), 1'b0);
            end
            else
            begin
                k = $urandom_range(1, 3);
                for (i = 0; i < k; i++)
                begin
                    send_item(pick_space(), 1'b0);
                    if ($urandom_range(0, 5) == 0)
                        send_item(pick_drop(), 1'b0);
                end
            end
        end
    endtask

    task automatic apb_write(logic [7:0] w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINE_WIDTH;
        pwdata  <= {24'd0, w};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        while (model.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic change_width(logic [7:0] w);
        s_tvalid <= 1'b0;
        drain();
        apb_write(w);
        model.set_width(w);
    endtask

    initial
    begin
        model      = new();
        tx_quiet   = 1'b0;
        rx_quiet   = 1'b0;
        hold_reqs  = 0;
        req_count  = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // leading blank and punctuation, dropped bytes, punctuation join, over-long word
        send_item(CHAR_SP, 1'b0);
        send_item("!", 1'b0);
        send_item("a", 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'd9, 1'b0);
        send_item(",", 1'b0);
        send_item(8'd13, 1'b0);
        send_text("Z0123456789");
        send_item(CHAR_SP, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h00, 1'b1);

        // narrowest line: every word over-fills a line of its own
        change_width(8'd1);
        random_phase(20);

        // widest line, receiver stalls long while the sender keeps offering
        change_width(8'd255);
        tx_quiet = 1'b1;
        send_text("abcdefgh ");
        hold_reqs++;
        random_phase(20);
        tx_quiet = 1'b0;

        mid_width = 8'($urandom_range(2, 254));
        change_width(mid_width);
        random_phase(20);

        // no idling on either side
        change_width(8'd12);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        random_phase(20);
        send_item(8'h00, 1'b1);
        s_tvalid <= 1'b0;

        drain();
        $display("covered %0d input requests in %0d texts, %0d output bytes checked",
                 req_count, model.texts, model.checked);
        $display("line widths 40, 1, 255, %0d and 12; %0d over-long words replaced",
                 mid_width, model.long_words);
        if (model.mismatches == 0 && model.pending() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d mismatches, %0d bytes still expected",
                     model.mismatches, model.pending());
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== text_normalize_and_word_wrap.f =====
hdl/tnww_pkg.sv
hdl/tnww_word_ram.sv
hdl/text_normalize_and_word_wrap.sv
verif/text_normalize_and_word_wrap_test.sv
